### src/dq_pkg.sv
// Shared types and codes for the double-ended queue.
// Holds the command and status codes and the controller-to-datapath struct.
// No dependencies.
package dq_pkg;

  // Command codes on op_i
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_CLEAR      = 3'd4,
    OP_REVERSE    = 3'd5,
    OP_NOP        = 3'd6
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Strobes from the controller to the datapath
  typedef struct packed {
    logic load;  // latch the incoming command word
    logic exec;  // update pointers, count and slot memory
    logic read;  // fetch the end words into the read registers
  } ctrl_t;

endpackage

### src/dq_ctrl.sv
// Sequencer for the double-ended queue.
// Steps each command through execute, read and response cycles.
// Depends on dq_pkg.
module dq_ctrl
  import dq_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  output logic  busy_o,
  output logic  done_o,
  output ctrl_t ctrl_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  // Take a command in idle or while the previous response is shown
  assign busy_o = (state_q != S_IDLE) && (state_q != S_RESP);
  assign accept = start_i && !busy_o;
  assign done_o = (state_q == S_RESP);

  assign ctrl_o.load = accept;
  assign ctrl_o.exec = (state_q == S_EXEC);
  assign ctrl_o.read = (state_q == S_READ);

  // Advance through the command phases
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_EXEC;
      S_EXEC: state_d = S_READ;
      S_READ: state_d = S_RESP;
      S_RESP: state_d = accept ? S_EXEC : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/dq_datapath.sv
// Ring-buffer datapath for the double-ended queue.
// Holds the slot memory, head pointer, word count, direction bit and result registers.
// Depends on dq_pkg.
module dq_datapath
  import dq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_t              ctrl_i,
  input  logic [2:0]         op_i,
  input  logic signed [31:0] value_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] front_value_o,
  output logic signed [31:0] back_value_o,
  output logic [4:0]         count_o,
  output logic               is_empty_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];

  logic [2:0]            op_q;
  logic [DATA_WIDTH-1:0] word_q;
  logic [AW-1:0]         head_q, head_d;
  logic [CW-1:0]         count_q, count_d;
  logic                  rev_q, rev_d;
  status_e               status_q, status_d;
  logic [DATA_WIDTH-1:0] first_q, last_q;

  logic                  full, empty, to_first;
  logic [AW-1:0]         head_dec, head_inc, tail_addr, last_addr, wr_addr;
  logic [SW-1:0]         tail_sum, last_sum;
  logic                  wr_en;
  logic [63:0]           value_ext;
  logic [63:0]           front_ext, back_ext;
  logic [DATA_WIDTH-1:0] front_word, back_word;

  // Latch the command word, keeping the low bits of the sign-extended value
  assign value_ext = 64'(value_i);
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      op_q   <= op_i;
      word_q <= value_ext[DATA_WIDTH-1:0];
    end
  end

  // Neighbor slots of the head and the slot past the last word
  assign full     = (count_q == CW'(DEPTH));
  assign empty    = (count_q == '0);
  assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
  assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
  assign tail_sum = SW'(head_q) + SW'(count_q);
  assign tail_addr = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);

  // Map the logical end onto the physical end through the direction bit
  assign to_first = ((op_e'(op_q) == OP_PUSH_FRONT) || (op_e'(op_q) == OP_POP_FRONT)) ^ rev_q;

  // Decode the command into pointer, count and memory updates
  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    rev_d    = rev_q;
    status_d = ST_DONE;
    wr_en    = 1'b0;
    wr_addr  = tail_addr;
    case (op_e'(op_q)) inside
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + CW'(1);
          if (to_first) begin
            head_d  = head_dec;
            wr_addr = head_dec;
          end
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          count_d = count_q - CW'(1);
          if (to_first) head_d = head_inc;
        end
      end
      OP_CLEAR:   count_d = '0;
      OP_REVERSE: rev_d = ~rev_q;
      default:    ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      count_q  <= '0;
      rev_q    <= 1'b0;
      status_q <= ST_DONE;
    end else if (ctrl_i.exec) begin
      head_q   <= head_d;
      count_q  <= count_d;
      rev_q    <= rev_d;
      status_q <= status_d;
    end
  end

  // Slot of the last word; falls back to the head when empty
  assign last_sum  = SW'(head_q) + SW'(count_q) - SW'(1);
  assign last_addr = empty ? head_q :
                     (last_sum >= SW'(DEPTH)) ? AW'(last_sum - SW'(DEPTH)) : AW'(last_sum);

  // Write pushed words and fetch both ends with registered reads
  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec && wr_en) begin
      mem_q[wr_addr] <= word_q;
    end
    if (ctrl_i.read) begin
      first_q <= mem_q[head_q];
      last_q  <= mem_q[last_addr];
    end
  end

  // Swap ends when reversed and report all ones when empty
  assign front_word = rev_q ? last_q : first_q;
  assign back_word  = rev_q ? first_q : last_q;
  assign front_ext  = 64'(signed'(front_word));
  assign back_ext   = 64'(signed'(back_word));

  assign status_o      = status_q;
  assign front_value_o = empty ? '1 : front_ext[31:0];
  assign back_value_o  = empty ? '1 : back_ext[31:0];
  assign count_o       = 5'(count_q);
  assign is_empty_o    = empty;

endmodule

### src/double_ended_queue.sv
// Double-ended queue of signed words in a ring buffer of DEPTH slots: push or pop at
// either end, clear, reverse. Issue a command by raising start_i while busy_o is low.
// Each command passes through an execute state that updates the head pointer, count
// and slot memory, a read state that reads the two end words from the slot memory,
// and a response state in which the result is shown on done_o; the next command may
// be issued in that response state. The result is valid for one cycle only and
// cannot be held off. The slot memory is not cleared at reset; only stored words are
// ever reported. Top level; depends on dq_pkg, dq_ctrl and dq_datapath.
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         op_i,
  input  logic signed [31:0] value_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] front_value_o,
  output logic signed [31:0] back_value_o,
  output logic [4:0]         count_o,
  output logic               is_empty_o
);

  ctrl_t ctrl;

  // Sequence the command phases
  dq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .ctrl_o (ctrl)
  );

  // Hold the ring buffer and the result registers
  dq_datapath #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .op_i         (op_i),
    .value_i      (value_i),
    .status_o     (status_o),
    .front_value_o(front_value_o),
    .back_value_o (back_value_o),
    .count_o      (count_o),
    .is_empty_o   (is_empty_o)
  );

`ifndef SYNTHESIS
  // A result strobe lasts one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("done_o held for more than one cycle");

  // An accepted command makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start_i && !busy_o) |=> busy_o)
    else $error("command accepted but busy_o not raised");

  // A result follows its command once it has passed the execute and read states
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (start_i && !busy_o) |-> ##3 done_o)
    else $error("result strobe missing after command");

  // An empty queue reports all ones at both ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (done_o && is_empty_o) |-> (front_value_o == '1) && (back_value_o == '1))
    else $error("empty queue reported an end word");
`endif

endmodule
